// File: sv/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types and codes for the i2c master bit engine
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // op codes on the input channel
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;
    localparam logic [2:0] OP_POLL  = 3'd5;
    localparam logic [2:0] OP_ACK   = 3'd6;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd250;
    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

    // decoded command, also the engine's running command
    typedef enum logic [6:0] {
        CMD_IDLE  = 7'b0000001,
        CMD_START = 7'b0000010,
        CMD_STOP  = 7'b0000100,
        CMD_WRITE = 7'b0001000,
        CMD_READ  = 7'b0010000,
        CMD_POLL  = 7'b0100000,
        CMD_ACK   = 7'b1000000
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] wdata;
        logic       sda_in;
    } in_t;

    typedef struct packed {
        logic       scl;
        logic       sda_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rdata;
        logic       ack_in;
    } out_t;

    // one classified tick as it sits in the queue
    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] wdata;
        logic       sda;
    } tick_t;

endpackage

// File: sv/i2c_master_bit_engine_core.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core
// i2c master bit engine: start, stop, byte write/read, ack poll and send ack
// ----------------------------------------------------------------------------
// Each transfer on the in channel is one system tick: an op (none, start,
// stop, write byte, read byte, poll ack, send ack), the byte to write and
// the sampled sda level. Every tick yields exactly one transfer on the out
// channel with the scl level, the sda pull-down, busy and done flags, the
// last read byte and the last ack sample. Ops arriving while a command runs
// are dropped. Each scl/sda segment lasts half_period_ticks ticks; the user
// must write it via cfg_wr_en/cfg_wr_data between commands, which the block
// does not enforce (reset value 250). A tick is decoded in the front, held in
// a two-entry queue, and executed by the bit engine into an output register.
// Throughput is one tick per clock unless out_ready stalls. When out_ready is
// low the output register holds, the queue fills its two entries and in_ready
// drops. Reset releases the bus (scl high, sda released), clears the engine
// to idle and restores the half period.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core
    import i2cm_pkg::*;
#(
    parameter int TICK_COUNTER_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_t        out_data,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic  push;
    tick_t push_data;
    logic  queue_full;
    logic  pop;
    logic  not_empty;
    tick_t pop_data;

    i2cm_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push       (push),
        .push_data  (push_data),
        .queue_full (queue_full)
    );

    i2cm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_data  (pop_data)
    );

    i2cm_back #(
        .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .not_empty   (not_empty),
        .pop_data    (pop_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

// File: sv/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// takes input ticks and decodes the op field into a command
// ----------------------------------------------------------------------------
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic  in_valid,
    output logic  in_ready,
    input  in_t   in_data,
    output logic  push,
    output tick_t push_data,
    input  logic  queue_full
);

    cmd_t cmd;

    always_comb
    begin
        unique case (in_data.op)
            OP_START: cmd = CMD_START;
            OP_STOP:  cmd = CMD_STOP;
            OP_WRITE: cmd = CMD_WRITE;
            OP_READ:  cmd = CMD_READ;
            OP_POLL:  cmd = CMD_POLL;
            OP_ACK:   cmd = CMD_ACK;
            // none and the unused code carry no command
            default:  cmd = CMD_IDLE;
        endcase
    end

    assign in_ready        = ~queue_full;
    assign push            = in_valid & ~queue_full;
    assign push_data.cmd   = cmd;
    assign push_data.wdata = in_data.wdata;
    assign push_data.sda   = in_data.sda_in;

endmodule

// File: sv/i2cm_queue.sv
// ----------------------------------------------------------------------------
// i2cm_queue
// two-entry queue between the decode front and the bit engine
// ----------------------------------------------------------------------------
module i2cm_queue
    import i2cm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  tick_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output tick_t pop_data
);

    tick_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full      = count_reg[1];
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

endmodule

// File: sv/i2cm_back.sv
// ----------------------------------------------------------------------------
// i2cm_back
// bit engine: plays commands out as timed scl/sda segments, one tick per item
// ----------------------------------------------------------------------------
module i2cm_back
    import i2cm_pkg::*;
#(
    parameter int TICK_COUNTER_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        not_empty,
    input  tick_t       pop_data,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output out_t        out_data
);

    localparam int TW = TICK_COUNTER_WIDTH;
    localparam logic [TW-1:0] TICK_MAX = '1;

    logic [15:0]   half_period_reg;
    logic [TW-1:0] seg_len;

    cmd_t          cmd_reg, cmd_next;
    logic [2:0]    phase_reg, phase_next;
    logic [3:0]    bit_index_reg, bit_index_next;
    logic [TW-1:0] tick_count_reg, tick_count_next;
    logic [7:0]    shifter_reg, shifter_next;
    logic          scl_reg, scl_next;
    logic          sda_pull_reg, sda_pull_next;
    logic          ack_bit_reg, ack_bit_next;
    logic [7:0]    rdata_reg, rdata_next;
    logic          out_valid_reg;
    out_t          out_data_reg, out_data_next;
    logic          busy;
    logic          done;
    logic          seg_end;

    // zero acts as one, values past the counter saturate
    always_comb
    begin
        priority if (half_period_reg == 16'd0)
            seg_len = TW'(1);
        else if (32'(half_period_reg) > 32'(TICK_MAX))
            seg_len = TICK_MAX;
        else
            seg_len = TW'(half_period_reg);
    end

    assign pop = not_empty & (~out_valid_reg | out_ready);

    always_comb
    begin
        cmd_next        = cmd_reg;
        phase_next      = phase_reg;
        bit_index_next  = bit_index_reg;
        tick_count_next = tick_count_reg;
        shifter_next    = shifter_reg;
        scl_next        = scl_reg;
        sda_pull_next   = sda_pull_reg;
        ack_bit_next    = ack_bit_reg;
        rdata_next      = rdata_reg;
        busy            = 1'b0;
        done            = 1'b0;
        seg_end         = 1'b0;

        // new command only when idle
        if (cmd_reg == CMD_IDLE && pop_data.cmd != CMD_IDLE)
        begin
            cmd_next        = pop_data.cmd;
            phase_next      = 3'd0;
            bit_index_next  = 4'd0;
            tick_count_next = '0;
            if (pop_data.cmd == CMD_WRITE)
                shifter_next = pop_data.wdata;
            if (pop_data.cmd == CMD_READ)
                shifter_next = 8'd0;
            // sda already high: skip the release under scl low
            if (pop_data.cmd == CMD_START)
                phase_next = pop_data.sda ? 3'd2 : 3'd0;
        end

        if (cmd_next != CMD_IDLE)
        begin
            busy = 1'b1;

            if (tick_count_next == '0)
            begin
                unique case (cmd_next)
                    CMD_START:
                    begin
                        unique case (phase_next)
                            3'd0:    scl_next = 1'b0;
                            3'd1:    sda_pull_next = 1'b0;
                            3'd2:    scl_next = 1'b1;
                            default: sda_pull_next = 1'b1;
                        endcase
                    end
                    CMD_STOP:
                    begin
                        unique case (phase_next)
                            3'd0:    scl_next = 1'b0;
                            3'd1:    sda_pull_next = 1'b1;
                            3'd2:    scl_next = 1'b1;
                            default: sda_pull_next = 1'b0;
                        endcase
                    end
                    CMD_WRITE:
                    begin
                        unique case (phase_next)
                            3'd0:    scl_next = 1'b0;
                            3'd1:    sda_pull_next = ~shifter_next[7];
                            default: scl_next = 1'b1;
                        endcase
                    end
                    CMD_READ:
                    begin
                        if (phase_next == 3'd0)
                            scl_next = 1'b0;
                        else
                        begin
                            sda_pull_next = 1'b0;
                            scl_next      = 1'b1;
                        end
                    end
                    CMD_POLL:
                    begin
                        if (phase_next == 3'd0)
                        begin
                            scl_next      = 1'b0;
                            sda_pull_next = 1'b0;
                        end
                        else
                            scl_next = 1'b1;
                    end
                    CMD_ACK:
                    begin
                        unique case (phase_next)
                            3'd0:    scl_next = 1'b0;
                            3'd1:    sda_pull_next = 1'b1;
                            default: scl_next = 1'b1;
                        endcase
                    end
                    default: ;
                endcase
            end

            seg_end = ({1'b0, tick_count_next} + (TW+1)'(1)) >= {1'b0, seg_len};

            if (seg_end)
            begin
                tick_count_next = '0;
                unique case (cmd_next)
                    CMD_START, CMD_STOP:
                    begin
                        if (phase_next >= 3'd3)
                            done = 1'b1;
                        else
                            phase_next = phase_next + 3'd1;
                    end
                    CMD_WRITE:
                    begin
                        if (phase_next < 3'd2)
                            phase_next = phase_next + 3'd1;
                        else
                        begin
                            shifter_next   = {shifter_next[6:0], 1'b0};
                            bit_index_next = bit_index_next + 4'd1;
                            phase_next     = 3'd0;
                            done           = (bit_index_next >= BITS_PER_BYTE);
                        end
                    end
                    CMD_READ:
                    begin
                        if (phase_next == 3'd0)
                            phase_next = 3'd1;
                        else
                        begin
                            shifter_next   = {shifter_next[6:0], pop_data.sda};
                            bit_index_next = bit_index_next + 4'd1;
                            phase_next     = 3'd0;
                            if (bit_index_next >= BITS_PER_BYTE)
                            begin
                                rdata_next = shifter_next;
                                done       = 1'b1;
                            end
                        end
                    end
                    CMD_POLL:
                    begin
                        if (phase_next == 3'd0)
                            phase_next = 3'd1;
                        else
                        begin
                            ack_bit_next = pop_data.sda;
                            done         = 1'b1;
                        end
                    end
                    CMD_ACK:
                    begin
                        if (phase_next >= 3'd2)
                            done = 1'b1;
                        else
                            phase_next = phase_next + 3'd1;
                    end
                    default: done = 1'b1;
                endcase

                if (done)
                begin
                    cmd_next   = CMD_IDLE;
                    phase_next = 3'd0;
                end
            end
            else
            begin
                tick_count_next = tick_count_next + TW'(1);
            end
        end

        out_data_next.scl      = scl_next;
        out_data_next.sda_low  = sda_pull_next;
        out_data_next.busy_res = busy;
        out_data_next.done_res = done;
        out_data_next.rdata    = rdata_next;
        out_data_next.ack_in   = ack_bit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            cmd_reg         <= CMD_IDLE;
            phase_reg       <= 3'd0;
            bit_index_reg   <= 4'd0;
            tick_count_reg  <= '0;
            shifter_reg     <= 8'd0;
            scl_reg         <= 1'b1;
            sda_pull_reg    <= 1'b0;
            ack_bit_reg     <= 1'b1;
            rdata_reg       <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                half_period_reg <= cfg_wr_data;
            if (pop)
            begin
                cmd_reg        <= cmd_next;
                phase_reg      <= phase_next;
                bit_index_reg  <= bit_index_next;
                tick_count_reg <= tick_count_next;
                shifter_reg    <= shifter_next;
                scl_reg        <= scl_next;
                sda_pull_reg   <= sda_pull_next;
                ack_bit_reg    <= ack_bit_next;
                rdata_reg      <= rdata_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
